>>> rtl/skts_pkg.sv
`timescale 1ns / 1ps
package skts_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int TAG_W       = 16;
    localparam int POS_W       = 4;

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SORT,
        S_SEARCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } rec_t;

    typedef struct packed {
        logic             load_en;
        logic [IDX_W-1:0] load_idx;
        rec_t             load_rec;
        logic             sort_en;
        logic             phase;
        logic [CNT_W-1:0] count;
    } cell_ctl_t;

endpackage

>>> rtl/skts_if.sv
`timescale 1ns / 1ps
interface skts_req_if;
    import skts_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        record_tag;
    logic                    end_of_set;

    modport source (output valid, output op, output key, output record_tag,
                    output end_of_set, input ready);
    modport sink   (input valid, input op, input key, input record_tag,
                    input end_of_set, output ready);
endinterface

interface skts_rsp_if;
    import skts_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;
    logic [TAG_W-1:0] match_tag;

    modport source (output valid, output found, output position, output match_tag,
                    input ready);
    modport sink   (input valid, input found, input position, input match_tag,
                    output ready);
endinterface

>>> rtl/skts_cell.sv
`timescale 1ns / 1ps
module skts_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  skts_pkg::cell_ctl_t    ctl,
    input  logic [skts_pkg::IDX_W-1:0] my_idx,
    input  skts_pkg::rec_t         left_rec,
    input  logic                   left_gt,
    input  skts_pkg::rec_t         right_rec,
    output skts_pkg::rec_t         rec,
    output logic                   gt
);
    import skts_pkg::*;

    rec_t             rec_reg;
    rec_t             rec_next;
    logic [CNT_W-1:0] idx_ext;
    logic             act_left;
    logic             act_right;

    assign idx_ext = CNT_W'(my_idx);
    assign gt      = rec_reg.key > right_rec.key;
    assign rec     = rec_reg;

    // left member of a compare pair in this phase, or right member
    assign act_left  = ctl.sort_en && (my_idx[0] == ctl.phase) &&
                       ((idx_ext + CNT_W'(1)) < ctl.count);
    assign act_right = ctl.sort_en && (my_idx != '0) && (my_idx[0] != ctl.phase) &&
                       (idx_ext < ctl.count);

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.load_en && (ctl.load_idx == my_idx))
        begin
            rec_next = ctl.load_rec;
        end
        else if (act_left && gt)
        begin
            rec_next = right_rec;
        end
        else if (act_right && left_gt)
        begin
            rec_next = left_rec;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    logic unused_rst;
    assign unused_rst = rst_n;

endmodule

>>> rtl/sorted_key_table_search.sv
`timescale 1ns / 1ps
// Sorted key table with binary search.
//
// req: one transfer per item. op = 0 loads a record (key, record_tag) into the
// next free slot; end_of_set on a load closes the set and sorts it. A load after
// a closed set starts a new set. Loads beyond TABLE_DEPTH records are dropped.
// op = 1 searches the closed set for key.
// rsp: one transfer per search: found, sorted position and the matching tag
// (position and tag are 0 when not found). Loads give no response.
//
// Sequence: a closing load then runs TABLE_DEPTH odd-even compare/swap passes
// along the row of cells. A search is accepted, then runs binary-search steps
// (one cell read and one 32-bit compare per cycle; a miss ends with a step
// that finds the range empty), then moves into the output register. One item
// is in work at a time.
// A response waits in the output register while rsp.ready is low; loads are
// still accepted meanwhile; a later search runs, then waits in S_DONE until it frees.
// Reset clears the entry count, the closed flag, the state and rsp.valid;
// stored records are not cleared.
module sorted_key_table_search (
    input logic  clk,
    input logic  rst_n,
    skts_req_if.sink   req,
    skts_rsp_if.source rsp
);
    import skts_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             closed_reg, closed_next;
    logic [CNT_W-1:0] pass_reg, pass_next;
    logic [CNT_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic signed [KEY_W-1:0] target_reg, target_next;
    logic             hit_reg, hit_next;
    logic [POS_W-1:0] hpos_reg, hpos_next;
    logic [TAG_W-1:0] htag_reg, htag_next;
    logic             ovalid_reg, ovalid_next;
    logic             ofound_reg, ofound_next;
    logic [POS_W-1:0] opos_reg, opos_next;
    logic [TAG_W-1:0] otag_reg, otag_next;

    cell_ctl_t        ctl;
    rec_t             cell_rec [TABLE_DEPTH];
    logic             cell_gt  [TABLE_DEPTH];

    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid_full;
    logic [IDX_W-1:0] mid;
    logic [IDX_W+POS_W-1:0] mid_ext;
    rec_t             probe;
    logic [CNT_W-1:0] base;
    logic             accept;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            rec_t l_rec, r_rec;
            logic l_gt;
            if (g == 0)
            begin : g_first
                assign l_rec = '0;
                assign l_gt  = 1'b0;
            end
            else
            begin : g_mid_l
                assign l_rec = cell_rec[g-1];
                assign l_gt  = cell_gt[g-1];
            end
            if (g == TABLE_DEPTH - 1)
            begin : g_last
                assign r_rec = '0;
            end
            else
            begin : g_mid_r
                assign r_rec = cell_rec[g+1];
            end
            skts_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .my_idx    (IDX_W'(g)),
                .left_rec  (l_rec),
                .left_gt   (l_gt),
                .right_rec (r_rec),
                .rec       (cell_rec[g]),
                .gt        (cell_gt[g])
            );
        end
    endgenerate

    assign mid_sum  = {1'b0, first_reg} + {1'b0, hi_reg} - (CNT_W+1)'(1);
    assign mid_full = mid_sum[CNT_W:1];
    assign mid      = mid_full[IDX_W-1:0];
    assign mid_ext  = {{POS_W{1'b0}}, mid};
    assign probe    = cell_rec[mid];
    assign base     = closed_reg ? '0 : count_reg;

    assign req.ready     = (state_reg == S_IDLE);
    assign accept        = req.valid && req.ready;
    assign rsp.valid     = ovalid_reg;
    assign rsp.found     = ofound_reg;
    assign rsp.position  = opos_reg;
    assign rsp.match_tag = otag_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        closed_next = closed_reg;
        pass_next   = pass_reg;
        first_next  = first_reg;
        hi_next     = hi_reg;
        target_next = target_reg;
        hit_next    = hit_reg;
        hpos_next   = hpos_reg;
        htag_next   = htag_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        ofound_next = ofound_reg;
        opos_next   = opos_reg;
        otag_next   = otag_reg;

        ctl.load_en      = 1'b0;
        ctl.load_idx     = base[IDX_W-1:0];
        ctl.load_rec.key = req.key;
        ctl.load_rec.tag = req.record_tag;
        ctl.sort_en      = (state_reg == S_SORT);
        ctl.phase        = pass_reg[0];
        ctl.count        = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op_t'(req.op) == OP_LOAD)
                    begin
                        closed_next = 1'b0;
                        count_next  = base;
                        if (base < CNT_W'(TABLE_DEPTH))
                        begin
                            ctl.load_en = 1'b1;
                            count_next  = base + CNT_W'(1);
                        end
                        if (req.end_of_set)
                        begin
                            closed_next = 1'b1;
                            pass_next   = '0;
                            state_next  = S_SORT;
                        end
                    end
                    else
                    begin
                        target_next = req.key;
                        first_next  = '0;
                        hi_next     = closed_reg ? count_reg : '0;
                        hit_next    = 1'b0;
                        hpos_next   = '0;
                        htag_next   = '0;
                        state_next  = S_SEARCH;
                    end
                end
            end
            S_SORT:
            begin
                pass_next = pass_reg + CNT_W'(1);
                if (pass_reg == CNT_W'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (first_reg < hi_reg)
                begin
                    if (probe.key == target_reg)
                    begin
                        hit_next   = 1'b1;
                        hpos_next  = mid_ext[POS_W-1:0];
                        htag_next  = probe.tag;
                        state_next = S_DONE;
                    end
                    else if (probe.key > target_reg)
                    begin
                        hi_next = mid_full;
                    end
                    else
                    begin
                        first_next = mid_full + CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ofound_next = hit_reg;
                    opos_next   = hpos_reg;
                    otag_next   = htag_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            closed_reg <= 1'b0;
            pass_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            closed_reg <= closed_next;
            pass_reg   <= pass_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        hi_reg     <= hi_next;
        target_reg <= target_next;
        hit_reg    <= hit_next;
        hpos_reg   <= hpos_next;
        htag_reg   <= htag_next;
        ofound_reg <= ofound_next;
        opos_reg   <= opos_next;
        otag_reg   <= otag_next;
    end

endmodule

>>> rtl/skts_checker.sv
`timescale 1ns / 1ps
module skts_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        in_op,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        out_found,
    input logic [skts_pkg::POS_W-1:0]  out_position,
    input logic [skts_pkg::TAG_W-1:0]  out_match_tag
);
    import skts_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response dropped while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_found |-> (out_position == '0) && (out_match_tag == '0))
        else $error("miss response carries nonzero fields");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_op == OP_LOAD) && !out_valid |=> !out_valid)
        else $error("load produced a response");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_op == OP_SEARCH) |=> !in_ready)
        else $error("request taken during search");

endmodule

bind sorted_key_table_search skts_checker u_skts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (req.valid),
    .in_ready      (req.ready),
    .in_op         (req.op),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_found     (rsp.found),
    .out_position  (rsp.position),
    .out_match_tag (rsp.match_tag)
);
